FILE: sv/sbda_pkg.sv
// shared types and constants for the signed binary to decimal ascii converter
// no dependencies; imported by the controller, datapath and top level
package sbda_pkg;

    localparam int NUM_DIGITS = 20;
    localparam int DIGIT_BITS = 4;
    localparam int STEP_BITS  = 4;
    localparam int SCAN_W     = $clog2(NUM_DIGITS);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic sign_emit;
        logic scan_step;
    } t_ctrl;

    typedef struct packed {
        logic conv_done;
        logic negative;
        logic scan_last;
    } t_stat;

endpackage

FILE: sv/sbda_ctrl.sv
// sequencing state machine for the converter
// depends on sbda_pkg; drives sbda_datapath through t_ctrl and reads t_stat
module sbda_ctrl
    import sbda_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        busy    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                o_ctrl.conv_step = 1'b1;
                if (i_stat.conv_done) begin
                    n_state = i_stat.negative ? ST_SIGN : ST_SCAN;
                end
            end
            ST_SIGN: begin
                o_ctrl.sign_emit = 1'b1;
                n_state          = ST_SCAN;
            end
            ST_SCAN: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/sbda_datapath.sv
// magnitude register, shift-add-3 bcd converter and character output register
// depends on sbda_pkg; commanded by sbda_ctrl
module sbda_datapath
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_value,
    input  t_ctrl       i_ctrl,
    output t_stat       o_stat,
    output logic [7:0]  o_char_code,
    output logic        o_last_char,
    output logic        o_strobe
);

    localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W = STEPS * STEP_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int BCD_W = NUM_DIGITS * DIGIT_BITS;

    logic [PAD_W-1:0]  r_bin;
    logic [PAD_W-1:0]  n_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [BCD_W-1:0]  n_bcd;
    logic [CNT_W-1:0]  r_count;
    logic [SCAN_W-1:0] r_scan;
    logic              r_neg;
    logic              r_seen;

    logic [VALUE_WIDTH-1:0] w_val;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic [DIGIT_BITS-1:0]  w_top;
    logic                   w_scan_last;

    assign w_val       = i_value[VALUE_WIDTH-1:0];
    assign w_mag       = w_val[VALUE_WIDTH-1] ? (~w_val + VALUE_WIDTH'(1)) : w_val;
    assign w_top       = r_bcd[BCD_W-1 -: DIGIT_BITS];
    assign w_scan_last = (r_scan == SCAN_W'(NUM_DIGITS - 1));

    assign o_stat.conv_done = (r_count == '0);
    assign o_stat.negative  = r_neg;
    assign o_stat.scan_last = w_scan_last;

    // STEP_BITS double-dabble bits per conversion step (one step per cycle while in ST_CONVERT)
    always_comb begin
        logic [BCD_W-1:0] v_bcd;
        logic [PAD_W-1:0] v_bin;
        v_bcd = r_bcd;
        v_bin = r_bin;
        for (int k = 0; k < STEP_BITS; k++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (v_bcd[d*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
                    v_bcd[d*DIGIT_BITS +: DIGIT_BITS] =
                        v_bcd[d*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
                end
            end
            v_bcd = {v_bcd[BCD_W-2:0], v_bin[PAD_W-1]};
            v_bin = {v_bin[PAD_W-2:0], 1'b0};
        end
        n_bcd = v_bcd;
        n_bin = v_bin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_ctrl.sign_emit
                      | (i_ctrl.scan_step & (r_seen | (w_top != '0) | w_scan_last));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_bin   <= PAD_W'(w_mag);
            r_bcd   <= '0;
            r_neg   <= w_val[VALUE_WIDTH-1];
            r_count <= CNT_W'(STEPS - 1);
            r_scan  <= '0;
            r_seen  <= 1'b0;
        end
        if (i_ctrl.conv_step) begin
            r_bin   <= n_bin;
            r_bcd   <= n_bcd;
            r_count <= r_count - CNT_W'(1);
        end
        if (i_ctrl.sign_emit) begin
            o_char_code <= CHAR_MINUS;
            o_last_char <= 1'b0;
        end
        if (i_ctrl.scan_step) begin
            o_char_code <= CHAR_ZERO | 8'(w_top);
            o_last_char <= w_scan_last;
            r_bcd       <= {r_bcd[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
            r_seen      <= r_seen | (w_top != '0);
            r_scan      <= r_scan + SCAN_W'(1);
        end
    end

endmodule

FILE: sv/signed_binary_to_decimal_ascii.sv
// sequence: after start the value is loaded and converted by the 4-bit-per-step bcd shifter, an
// optional minus sign is emitted when negative, then the 20-digit scan emits the characters
// throughput: a new value is accepted only while busy is low, after the 20-digit scan ends;
// one character per strobe beat, receiver cannot stall
// reset: synchronous active-low, returns the sequencer to idle and clears the strobe
// top level of the converter; instantiates sbda_ctrl and sbda_datapath, uses sbda_pkg
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_value,
    output logic [7:0]  o_char_code,
    output logic        o_last_char,
    output logic        o_strobe
);

    t_ctrl w_ctrl;
    t_stat w_stat;

    sbda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    sbda_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char),
        .o_strobe    (o_strobe)
    );

endmodule
